### design/assert_macros.svh
// Assertion helpers used by the ssa_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/ssa_pkg.sv
package ssa_pkg;

  localparam logic [7:0] OPC_WRITE = 8'h02;
  localparam logic [7:0] OPC_READ  = 8'h03;
  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // frame is five bytes; slot index needs three bits
  localparam int FRAME_LEN = 5;
  localparam int SLOT_W    = 3;
  localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd4;
  localparam int BIT_W     = 3;
  localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

  localparam logic [7:0] DIV_RESET = 8'd16;
  localparam logic [7:0] DIV_MIN   = 8'd2;

  // two-entry queue between front and back; pointers wrap naturally
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [FRAME_LEN-1:0][7:0] bytes;     // bytes[0] goes out first
    logic                      is_read;
    logic [7:0]                returned;  // slave byte for the last slot
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_SHIFT
  } back_state_t;

endpackage

### design/ssa_front.sv
module ssa_front (
  input  logic           kind,
  input  logic [15:0]    address,
  input  logic [7:0]     write_value,
  input  logic [7:0]     returned_byte,
  output ssa_pkg::frame_t frame
);

  logic is_write;

  always_comb begin
    is_write       = (kind == ssa_pkg::KIND_WRITE);
    frame.bytes[0] = is_write ? ssa_pkg::OPC_WRITE : ssa_pkg::OPC_READ;
    frame.bytes[1] = ssa_pkg::ZERO_BYTE;
    frame.bytes[2] = address[15:8];
    frame.bytes[3] = address[7:0];
    frame.bytes[4] = is_write ? write_value : ssa_pkg::FILL_BYTE;
    frame.is_read  = !is_write;
    frame.returned = returned_byte;
  end

endmodule

### design/ssa_fifo.sv
module ssa_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ssa_pkg::frame_t      push_frame,
  input  logic                 pop,
  output ssa_pkg::frame_t      head,
  output ssa_pkg::q_status_t   status
);

  ssa_pkg::frame_t                  entries [ssa_pkg::QUEUE_DEPTH];
  logic [ssa_pkg::QPTR_W-1:0]       wr_ptr;
  logic [ssa_pkg::QPTR_W-1:0]       rd_ptr;
  logic [ssa_pkg::QCNT_W-1:0]       count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + ssa_pkg::QCNT_W'(push) - ssa_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_frame;
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == ssa_pkg::QCNT_W'(ssa_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

### design/ssa_back.sv
module ssa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         div,
  input  ssa_pkg::frame_t    head,
  input  ssa_pkg::q_status_t q_status,
  output logic               pop,
  output logic               strobe,
  output logic [7:0]         mosi_byte,
  output logic               last_byte,
  output logic [7:0]         read_data
);

  ssa_pkg::back_state_t          state, state_next;
  ssa_pkg::frame_t               frame;
  logic [ssa_pkg::SLOT_W-1:0]    slot;
  logic [ssa_pkg::BIT_W-1:0]     bit_idx;
  logic [7:0]                    cnt;
  logic [7:0]                    rx;

  logic [7:0] period;
  logic       bit_end, byte_end, frame_end, miso_bit;

  always_comb begin
    period    = (div < ssa_pkg::DIV_MIN) ? ssa_pkg::DIV_MIN : div;
    bit_end   = (state == ssa_pkg::BK_SHIFT) && (cnt == period - 8'd1);
    byte_end  = bit_end && (bit_idx == ssa_pkg::LAST_BIT);
    frame_end = byte_end && (slot == ssa_pkg::LAST_SLOT);
    // slave drives data only in the last slot of a read, MSB first
    miso_bit  = (frame.is_read && slot == ssa_pkg::LAST_SLOT) ?
                frame.returned[~bit_idx] : 1'b0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssa_pkg::BK_IDLE: begin
        if (!q_status.empty) state_next = ssa_pkg::BK_SHIFT;
      end
      ssa_pkg::BK_SHIFT: begin
        if (frame_end && q_status.empty) state_next = ssa_pkg::BK_IDLE;
      end
      default: state_next = ssa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (state)
      ssa_pkg::BK_IDLE:  pop = !q_status.empty;
      ssa_pkg::BK_SHIFT: pop = frame_end && !q_status.empty;
      default:           pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ssa_pkg::BK_IDLE;
      strobe  <= 1'b0;
      slot    <= '0;
      bit_idx <= '0;
      cnt     <= '0;
    end else begin
      state  <= state_next;
      strobe <= byte_end;
      if (pop) begin
        slot    <= '0;
        bit_idx <= '0;
        cnt     <= '0;
      end else if (state == ssa_pkg::BK_SHIFT) begin
        if (bit_end) begin
          cnt     <= '0;
          bit_idx <= bit_idx + 1'b1;
          if (byte_end) slot <= slot + 1'b1;
        end else begin
          cnt <= cnt + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) frame <= head;
    if (pop) begin
      rx <= '0;
    end else if (bit_end) begin
      rx <= {rx[6:0], miso_bit};
    end
    if (byte_end) begin
      mosi_byte <= frame.bytes[slot];
      last_byte <= (slot == ssa_pkg::LAST_SLOT);
      read_data <= {rx[6:0], miso_bit};
    end
  end

endmodule

### design/spi_serial_sram_access.sv
// SPI master for one-byte serial SRAM accesses. Each accepted beat
// (start high while busy is low) becomes a five-byte frame: command (0x02
// write, 0x03 read), a zero byte, address high, address low, then the data
// byte on a write or 0xFF on a read. One result beat per frame byte is shown
// for exactly one cycle with strobe high; the receiver cannot stall it, so
// sample every strobe. last_byte marks the fifth byte; read_data carries the
// captured slave byte on the fifth byte of a read and is zero otherwise. The
// bit shifter in the back end times each bit from clock_divider (values
// below 2 run as 2; the reset value is 16). A two-beat queue sits in front
// of the shifter, so busy rises only when two accesses are already waiting;
// write clock_divider only while idle.
module spi_serial_sram_access (
  input  logic        clk,
  input  logic        rst,
  // access request
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [15:0] address,
  input  logic [7:0]  write_value,
  input  logic [7:0]  returned_byte,
  // divider register
  input  logic        clock_divider_we,
  input  logic [7:0]  clock_divider_wdata,
  // result beats
  output logic        strobe,
  output logic [7:0]  mosi_byte,
  output logic        last_byte,
  output logic [7:0]  read_data
);

  logic [7:0]          clock_divider;
  logic                accept;
  logic                pop;
  ssa_pkg::frame_t     new_frame;
  ssa_pkg::frame_t     head;
  ssa_pkg::q_status_t  q_status;

  // divider is stored as written; back end clamps for timing
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_divider <= ssa_pkg::DIV_RESET;
    end else if (clock_divider_we) begin
      clock_divider <= clock_divider_wdata;
    end
  end

  assign busy   = q_status.full;
  assign accept = start && !busy;

  // front: build the frame bytes from the request
  ssa_front u_front (
    .kind          (kind),
    .address       (address),
    .write_value   (write_value),
    .returned_byte (returned_byte),
    .frame         (new_frame)
  );

  // queue decouples request side from the shifter
  ssa_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_frame (new_frame),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // back: shift each frame out bit by bit, one result beat per byte
  ssa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .div       (clock_divider),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .strobe    (strobe),
    .mosi_byte (mosi_byte),
    .last_byte (last_byte),
    .read_data (read_data)
  );

endmodule

### design/ssa_checker.sv
`include "assert_macros.svh"

module ssa_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       strobe,
  input logic [7:0] mosi_byte,
  input logic       last_byte,
  input logic [7:0] read_data
);

  // a whole byte is shifted between beats, so beats never touch
  `ASSERT_CLK(a_strobe_gap, strobe |=> !strobe, "back-to-back result beats")

  // only the last byte of a frame may carry read data
  `ASSERT_CLK(a_rd_only_last, (strobe && !last_byte) |-> (read_data == 8'h00),
              "read data on a non-final byte")

  // a last byte other than fill is a write, which returns nothing
  `ASSERT_CLK(a_rd_write_zero,
              (strobe && last_byte && mosi_byte != 8'hFF) |-> (read_data == 8'h00),
              "read data on a write frame")

  // reset leaves the block quiet and ready
  `ASSERT_CLK_ALWAYS(a_reset_quiet, (!rst && $past(rst)) |-> (!strobe && !busy),
                     "activity right after reset")

endmodule

bind spi_serial_sram_access ssa_checker u_ssa_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .strobe    (strobe),
  .mosi_byte (mosi_byte),
  .last_byte (last_byte),
  .read_data (read_data)
);

### dv/sram_frame_checker.sv
// Watches the access and result channels of the SRAM access master,
// predicts the five frame bytes of every accepted access and checks each
// result beat against the oldest prediction.
module sram_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        kind,
  input  logic [15:0] address,
  input  logic [7:0]  write_value,
  input  logic [7:0]  returned_byte,
  input  logic        strobe,
  input  logic [7:0]  mosi_byte,
  input  logic        last_byte,
  input  logic [7:0]  read_data,
  input  logic        sweep_done,
  output int          pending,
  output int          error_count
);

  typedef struct packed {
    logic [7:0] mosi;
    logic       last;
    logic [7:0] rdata;
  } frame_beat_t;

  frame_beat_t frame_beats_due[$];
  bit          leftovers_reported;

  task automatic report_mismatch(input string what);
    $display("%0t sram_frame_checker: %s", $time, what);
    error_count++;
  endtask

  // five beats per access: command, zero, addr hi, addr lo, data or fill
  task automatic push_frame(input logic k, input logic [15:0] a,
                            input logic [7:0] wv, input logic [7:0] rb);
    frame_beat_t b;
    b = '{mosi: ssa_pkg::OPC_READ, last: 1'b0, rdata: ssa_pkg::ZERO_BYTE};
    if (k == ssa_pkg::KIND_WRITE) b.mosi = ssa_pkg::OPC_WRITE;
    frame_beats_due.push_back(b);
    b.mosi = ssa_pkg::ZERO_BYTE;
    frame_beats_due.push_back(b);
    b.mosi = a[15:8];
    frame_beats_due.push_back(b);
    b.mosi = a[7:0];
    frame_beats_due.push_back(b);
    b.last = 1'b1;
    if (k == ssa_pkg::KIND_WRITE) begin
      b.mosi  = wv;
      b.rdata = ssa_pkg::ZERO_BYTE;
    end else begin
      b.mosi  = ssa_pkg::FILL_BYTE;
      b.rdata = rb;
    end
    frame_beats_due.push_back(b);
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      frame_beats_due.delete();
    end else begin
      if (start && !busy) push_frame(kind, address, write_value, returned_byte);
      if (strobe) begin
        if (frame_beats_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat mosi=%02h last=%0b rd=%02h",
                                    mosi_byte, last_byte, read_data));
        end else begin
          want = frame_beats_due.pop_front();
          if (mosi_byte !== want.mosi)
            report_mismatch($sformatf("mosi_byte %02h, want %02h", mosi_byte, want.mosi));
          if (last_byte !== want.last)
            report_mismatch($sformatf("last_byte %0b, want %0b", last_byte, want.last));
          if (read_data !== want.rdata)
            report_mismatch($sformatf("read_data %02h, want %02h", read_data, want.rdata));
        end
      end
      if (sweep_done && !leftovers_reported && frame_beats_due.size() != 0) begin
        leftovers_reported = 1'b1;
        report_mismatch($sformatf("%0d beats never arrived", frame_beats_due.size()));
      end
    end
    pending <= frame_beats_due.size();
  end

endmodule

### dv/spi_serial_sram_access_test.sv
// Top of the SRAM access master bench: clock, reset, access stimulus and the
// divider register sweep. All checking lives in sram_frame_checker and the
// bound ssa_checker; this module only drives and gives the verdict.
module spi_serial_sram_access_test;

  // The limit lies well above the slowest correct run (most phases use tiny
  // dividers).
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int ACCESSES_SMALL  = 62;   // per phase with a small divider
  localparam int ACCESSES_BIG    = 4;    // per phase with a huge divider
  localparam int NUM_DIV_PHASES  = 9;

  // sender gap modes
  localparam int GAP_RANDOM      = 0;
  localparam int GAP_NONE        = 1;
  localparam int GAP_MOSTLY_NONE = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        kind = ssa_pkg::KIND_READ;
  logic [15:0] address = '0;
  logic [7:0]  write_value = '0;
  logic [7:0]  returned_byte = '0;
  logic        clock_divider_we = 1'b0;
  logic [7:0]  clock_divider_wdata = '0;
  logic        strobe;
  logic [7:0]  mosi_byte;
  logic        last_byte;
  logic [7:0]  read_data;
  logic        sweep_done = 1'b0;

  int pending;
  int error_count;
  int cycles = 0;
  int sck_div_now = int'(ssa_pkg::DIV_RESET);  // mirror of the divider, used for the tail wait

  spi_serial_sram_access dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .kind                (kind),
    .address             (address),
    .write_value         (write_value),
    .returned_byte       (returned_byte),
    .clock_divider_we    (clock_divider_we),
    .clock_divider_wdata (clock_divider_wdata),
    .strobe              (strobe),
    .mosi_byte           (mosi_byte),
    .last_byte           (last_byte),
    .read_data           (read_data)
  );

  sram_frame_checker frame_check (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .kind                (kind),
    .address             (address),
    .write_value         (write_value),
    .returned_byte       (returned_byte),
    .strobe              (strobe),
    .mosi_byte           (mosi_byte),
    .last_byte           (last_byte),
    .read_data           (read_data),
    .sweep_done          (sweep_done),
    .pending             (pending),
    .error_count         (error_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("spi_serial_sram_access_test: done, errors");
      $finish;
    end
  end

  // One access beat. Caller is at a rising edge. start is only dropped when
  // a gap is taken, so back-to-back beats never see start toggled in one step.
  // Returns at the edge where the beat was taken (busy low, start high).
  task automatic issue_access(input logic k, input logic [15:0] a,
                              input logic [7:0] wv, input logic [7:0] rb,
                              input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    kind          <= k;
    address       <= a;
    write_value   <= wv;
    returned_byte <= rb;
    do @(posedge clk); while (busy);
  endtask

  // Hold the sender off until every predicted beat has shown up. pending is
  // registered, so do not look at it on the edge of the last acceptance.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Drain, then wait an idle span scaled by the effective divider before
  // touching the divider.
  task automatic settle_idle();
    int eff_div;
    eff_div = (sck_div_now < int'(ssa_pkg::DIV_MIN)) ? int'(ssa_pkg::DIV_MIN) : sck_div_now;
    drain_results();
    repeat (2 * eff_div + 4) @(posedge clk);
  endtask

  task automatic set_divider(input int value);
    settle_idle();
    clock_divider_we    <= 1'b1;
    clock_divider_wdata <= value[7:0];
    @(posedge clk);
    clock_divider_we    <= 1'b0;
    sck_div_now = value;
  endtask

  // random 0..6 every beat, back to back, or mostly back to back
  function automatic int draw_gap(input int mode);
    int g;
    case (mode)
      GAP_RANDOM: g = int'($urandom_range(0, 6));
      GAP_NONE:   g = 0;
      default:    g = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 6)) : 0;
    endcase
    return g;
  endfunction

  task automatic random_access(input int mode);
    logic [15:0] a;
    logic        k;
    k = $urandom_range(0, 1) ? ssa_pkg::KIND_WRITE : ssa_pkg::KIND_READ;
    case ($urandom_range(0, 7))
      0:       a = 16'h0000;
      1:       a = 16'hFFFF;
      default: a = 16'($urandom_range(0, 65535));
    endcase
    issue_access(k, a, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 draw_gap(mode));
  endtask

  int div_plan[NUM_DIV_PHASES] = '{2, 128, 3, 0, 1, 255, 7, 4, 2};

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset divider: address and data extremes, both
    // access kinds, returned byte on writes and write value on reads (both
    // ignored), alternating bit patterns.
    issue_access(ssa_pkg::KIND_WRITE, 16'h0000, 8'h00, 8'hFF, 0);
    issue_access(ssa_pkg::KIND_READ,  16'h0000, 8'hFF, 8'h00, 0);
    issue_access(ssa_pkg::KIND_WRITE, 16'hFFFF, 8'hFF, 8'h00, 0);
    issue_access(ssa_pkg::KIND_READ,  16'hFFFF, 8'h00, 8'hFF, 3);
    issue_access(ssa_pkg::KIND_WRITE, 16'h00FF, 8'h5A, 8'hA5, 0);
    issue_access(ssa_pkg::KIND_READ,  16'hFF00, 8'h5A, 8'hA5, 1);
    issue_access(ssa_pkg::KIND_WRITE, 16'hAAAA, 8'h55, 8'h33, 0);
    issue_access(ssa_pkg::KIND_READ,  16'h5555, 8'h11, 8'hAA, 6);
    issue_access(ssa_pkg::KIND_WRITE, 16'h1234, 8'h80, 8'h01, 0);
    issue_access(ssa_pkg::KIND_READ,  16'h8001, 8'h7F, 8'h01, 0);
    issue_access(ssa_pkg::KIND_READ,  16'h0100, 8'h00, 8'h80, 2);
    issue_access(ssa_pkg::KIND_WRITE, 16'h0001, 8'h01, 8'h00, 0);

    // Divider sweep: tiny values carry the bulk, 0/1 must run as 2, and
    // 128/255 get a handful of beats since each frame is very long there.
    for (int p = 0; p < NUM_DIV_PHASES; p++) begin
      set_divider(div_plan[p]);
      n = (div_plan[p] >= 64) ? ACCESSES_BIG : ACCESSES_SMALL;
      for (int i = 0; i < n; i++) begin
        // occasionally let everything in flight land before the next beat
        if ($urandom_range(0, 49) == 0) drain_results();
        random_access(p % 3);
      end
    end

    settle_idle();
    sweep_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (error_count == 0) begin
      $display("spi_serial_sram_access_test: done, clean");
    end else begin
      $display("spi_serial_sram_access_test: done, errors");
    end
    $finish;
  end

endmodule
